@@ hw/rtl/godl_pkg.sv @@
package godl_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 255;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);

  // Type codes below this use the short form
  localparam logic [7:0] SHORT_LIMIT = 8'd6;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_MISS
  } cmd_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } back_state_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  entry_index;
    logic [15:0] descriptor_word;
  } in_item_t;

  typedef struct packed {
    logic        in_range;
    logic [7:0]  flag_byte;
    logic [7:0]  size_bytes;
    logic        short_form;
    logic [15:0] data_offset;
  } out_item_t;

  // Classified work for the back end; addr is the zero-based entry
  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       word;
  } cmd_t;

  // Value size in bytes for a type code
  function automatic logic [7:0] size_of_code(input logic [7:0] code);
    logic [7:0] size;
    size = 8'd1;
    if (code > 8'd20) begin
      size = code - 8'd6;
    end else begin
      case (code)
        8'd8:    size = 8'd2;
        8'd9:    size = 8'd3;
        8'd10:   size = 8'd4;
        8'd11:   size = 8'd6;
        8'd12:   size = 8'd8;
        8'd13:   size = 8'd10;
        8'd14:   size = 8'd14;
        8'd15:   size = 8'd5;
        8'd16:   size = 8'd7;
        8'd17:   size = 8'd9;
        8'd18:   size = 8'd11;
        8'd19:   size = 8'd12;
        8'd20:   size = 8'd13;
        default: size = 8'd1;
      endcase
    end
    return size;
  endfunction

endpackage

@@ hw/rtl/group_object_descriptor_lookup_unit.sv @@
// Group object descriptor table with lookup. Load items (opcode 0) write one
// 16-bit descriptor (flag byte over type code) at a one-based entry and give no
// result; loads at entry 0 or beyond the table are dropped. Query items
// (opcode 1) return in_range, the flag byte, the decoded value size, the short
// form flag and the byte offset, which is the sum of the sizes of all earlier
// entries; queries outside 1 up to the configured object count return all
// zeros. A front end classifies items into a two-entry command queue, so input
// transfers keep flowing while the back end works, until the queue is full.
// In the back end a load writes the descriptor memory and an out-of-range query
// gives a zero result; an in-range query at entry N walks entries 1..N through
// the single read port of the descriptor memory. Write the object count only
// while the block is idle, and query only entries that were loaded since reset
// (together with all earlier ones).
module group_object_descriptor_lookup_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  godl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output godl_pkg::out_item_t out_data
);
  import godl_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  godl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  godl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  godl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/godl_front.sv @@
module godl_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  godl_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             push,
  output godl_pkg::cmd_t   push_cmd
);
  import godl_pkg::*;

  logic [7:0] obj_count;
  logic       idx_nonzero;
  logic       load_ok;
  logic       query_hit;

  // Object count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_count <= '0;
    end else if (cfg_valid) begin
      obj_count <= cfg_data;
    end
  end

  // Classify the incoming item
  assign idx_nonzero = (in_data.entry_index != 8'd0);
  assign load_ok     = idx_nonzero && (in_data.entry_index <= 8'(MAX_ENTRIES));
  assign query_hit   = load_ok && (in_data.entry_index <= obj_count);

  always_comb begin
    push_cmd.addr = ADDR_W'(in_data.entry_index - 8'd1);
    push_cmd.word = in_data.descriptor_word;
    if (in_data.opcode == OP_LOAD) begin
      push_cmd.kind = CMD_LOAD;
    end else if (query_hit) begin
      push_cmd.kind = CMD_QUERY;
    end else begin
      push_cmd.kind = CMD_MISS;
    end
  end

  // Out-of-bounds loads are taken and dropped here
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && ((in_data.opcode == OP_QUERY) || load_ok);

endmodule

@@ hw/rtl/godl_queue.sv @@
module godl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  godl_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output godl_pkg::cmd_t q_cmd
);
  import godl_pkg::*;

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/godl_back.sv @@
module godl_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  godl_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output godl_pkg::out_item_t out_data
);
  import godl_pkg::*;

  back_state_t       state;
  back_state_t       state_next;

  logic [15:0]       mem [MAX_ENTRIES];
  logic [15:0]       rd_data;

  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] last;
  logic [ADDR_W-1:0] rd_tag;
  logic              issuing;
  logic              rd_live;
  logic [15:0]       sum;

  logic              out_free;
  logic              mem_we;
  logic              start;
  logic              miss;
  logic              finish;

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && (q_cmd.kind == CMD_QUERY) && out_free) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_live && (rd_tag == last)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop  = 1'b0;
    mem_we = 1'b0;
    start  = 1'b0;
    miss   = 1'b0;
    finish = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            CMD_LOAD: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            CMD_MISS: begin
              q_pop = out_free;
              miss  = out_free;
            end
            CMD_QUERY: begin
              q_pop = out_free;
              start = out_free;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        finish = rd_live && (rd_tag == last);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Descriptor memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_cmd.addr] <= q_cmd.word;
    end
    rd_data <= mem[ptr];
  end

  // Walk entries 0..last, summing sizes of all but the last
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_live <= 1'b0;
    end else begin
      rd_live <= issuing;
      if (start) begin
        issuing <= 1'b1;
      end else if (issuing && (ptr == last)) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= ptr;
    if (start) begin
      last <= q_cmd.addr;
      ptr  <= '0;
      sum  <= '0;
    end else begin
      if (issuing && (ptr != last)) begin
        ptr <= ptr + 1'b1;
      end
      if (rd_live && !finish) begin
        sum <= sum + 16'(size_of_code(rd_data[7:0]));
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (miss || finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (miss) begin
      out_data <= '0;
    end else if (finish) begin
      out_data.in_range    <= 1'b1;
      out_data.flag_byte   <= rd_data[15:8];
      out_data.size_bytes  <= size_of_code(rd_data[7:0]);
      out_data.short_form  <= (rd_data[7:0] < SHORT_LIMIT);
      out_data.data_offset <= sum;
    end
  end

endmodule
